// ----- sv/cmap_pkg.sv -----
// Shared types and codes for the routing grid congestion map.
package cmap_pkg;

    // Item kinds carried in s_tuser
    localparam logic [1:0] KIND_SEG  = 2'd0;
    localparam logic [1:0] KIND_HIST = 2'd1;
    localparam logic [1:0] KIND_OVF  = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_GRID_W = 2'd0;
    localparam logic [1:0] REG_GRID_H = 2'd1;
    localparam logic [1:0] REG_HCAP   = 2'd2;
    localparam logic [1:0] REG_VCAP   = 2'd3;

    localparam int CAP_WIDTH = 16;
    localparam int FIELD_WIDTH = 16;
    localparam int TOTAL_WIDTH = 32;

    // Control into the edge unit
    typedef struct packed {
        logic vert;   // segment update targets the vertical half
        logic in_h;   // horizontal edge of this entry lies inside the grid
        logic in_v;   // vertical edge of this entry lies inside the grid
    } alu_ctrl_t;

    // One result transaction
    typedef struct packed {
        logic [TOTAL_WIDTH-1:0] total;
        logic [CAP_WIDTH-1:0]   capacity;
        logic [FIELD_WIDTH-1:0] history;
        logic [FIELD_WIDTH-1:0] demand;
        logic                   valid;
    } res_t;

endpackage

// ----- sv/cmap_ram.sv -----
// Single-write, single-read memory with registered read data.
module cmap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/cmap_alu.sv -----
// Edge unit: saturating demand update, history bump and overflow of one entry.
module cmap_alu #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic [2*COUNT_WIDTH-1:0]       dem_word,
    input  logic [2*COUNT_WIDTH-1:0]       hist_word,
    input  logic signed [7:0]              delta,
    input  logic [cmap_pkg::CAP_WIDTH-1:0] hcap,
    input  logic [cmap_pkg::CAP_WIDTH-1:0] vcap,
    input  cmap_pkg::alu_ctrl_t            ctrl,
    output logic [2*COUNT_WIDTH-1:0]       dem_word_new,
    output logic [COUNT_WIDTH-1:0]         dem_new,
    output logic [2*COUNT_WIDTH-1:0]       hist_word_new,
    output logic [cmap_pkg::TOTAL_WIDTH-1:0] ovh,
    output logic [cmap_pkg::TOTAL_WIDTH-1:0] ovv
);

    import cmap_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int OW = TOTAL_WIDTH + 1;

    logic [CW-1:0]          dem_h;
    logic [CW-1:0]          dem_v;
    logic [CW-1:0]          hist_h;
    logic [CW-1:0]          hist_v;
    logic [CW-1:0]          dem_cur;
    logic signed [CW+1:0]   dsum;
    logic [OW-1:0]          diff_h;
    logic [OW-1:0]          diff_v;
    logic                   gt_h;
    logic                   gt_v;

    assign dem_h  = dem_word[CW-1:0];
    assign dem_v  = dem_word[2*CW-1:CW];
    assign hist_h = hist_word[CW-1:0];
    assign hist_v = hist_word[2*CW-1:CW];

    // Clamp the signed update at zero and at the counter maximum
    always_comb
    begin
        dem_cur = ctrl.vert ? dem_v : dem_h;
        dsum = $signed({2'b00, dem_cur}) + $signed((CW + 2)'(delta));
        if (dsum[CW+1])
        begin
            dem_new = '0;
        end
        else if (dsum[CW])
        begin
            dem_new = '1;
        end
        else
        begin
            dem_new = dsum[CW-1:0];
        end
        dem_word_new = ctrl.vert ? {dem_new, dem_h} : {dem_v, dem_new};
    end

    always_comb
    begin
        diff_h = OW'(dem_h) - OW'(hcap);
        diff_v = OW'(dem_v) - OW'(vcap);
        gt_h   = ctrl.in_h && (OW'(dem_h) > OW'(hcap));
        gt_v   = ctrl.in_v && (OW'(dem_v) > OW'(vcap));
        ovh    = gt_h ? diff_h[TOTAL_WIDTH-1:0] : '0;
        ovv    = gt_v ? diff_v[TOTAL_WIDTH-1:0] : '0;
        hist_word_new[CW-1:0]    = (gt_h && !(&hist_h)) ? hist_h + CW'(1) : hist_h;
        hist_word_new[2*CW-1:CW] = (gt_v && !(&hist_v)) ? hist_v + CW'(1) : hist_v;
    end

endmodule

// ----- sv/routing_grid_congestion_map.sv -----
// Top level of the routing grid congestion map: sequencer, stores and stream ports.
// Demand and history counters of every grid edge live in two memories addressed by
// x*MAX_DIM+y, each word holding the horizontal counter in its low half and the
// vertical one in its high half. A segment update does one memory read, then the
// read-modify-write through the edge unit; an edge read only reads. A history update
// or overflow sum sweeps all MAX_DIM*MAX_DIM entries through the same unit, one entry
// per cycle. One item is worked at a time; a finished result waits in the output
// register while the next item is taken, or in a hold register, with input stalled,
// while the output one is full. After reset, and after each write of grid_width or
// grid_height, a clearing pass zeroes both memories; no item is accepted meanwhile.
module routing_grid_congestion_map #(
    parameter int MAX_DIM = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // from_x[5:0], from_y[11:6], to_x[17:12], to_y[23:18], delta[31:24],
    // edge_dir[32], zero fill[39:33]
    input  logic [39:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // edge_demand[15:0], edge_history[31:16], edge_capacity[47:32],
    // ovf_total[79:48]
    output logic [79:0] m_tdata,
    // edge_valid[0]
    output logic [0:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import cmap_pkg::*;

    localparam int CW    = COUNT_WIDTH;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_DIM);
    localparam int DW    = (((XW + 1) > 7) ? (XW + 1) : 7) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [XW-1:0] LAST_XY   = XW'(MAX_DIM - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEG,
        ST_READ,
        ST_SWEEP,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [6:0]            gw_reg;
    logic [6:0]            gh_reg;
    logic [CAP_WIDTH-1:0]  hcap_reg;
    logic [CAP_WIDTH-1:0]  vcap_reg;
    logic [AW-1:0]         cnt_reg;
    logic [XW-1:0]         x_reg;
    logic [XW-1:0]         y_reg;
    logic                  s1_v_reg;
    logic                  s2_v_reg;
    logic                  m_tvalid_reg;

    logic [1:0]            kind_reg;
    logic                  vert_reg;
    logic signed [7:0]     delta_reg;
    logic [AW-1:0]         addr_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic [XW-1:0]         s1_x_reg;
    logic [XW-1:0]         s1_y_reg;
    logic [TOTAL_WIDTH-1:0] ovh_reg;
    logic [TOTAL_WIDTH-1:0] ovv_reg;
    logic [TOTAL_WIDTH-1:0] sum_reg;
    logic [TOTAL_WIDTH-1:0] sum_next;
    res_t                  res_reg;
    res_t                  m_res_reg;

    // Input fields
    logic [1:0]        in_kind;
    logic [5:0]        in_fx;
    logic [5:0]        in_fy;
    logic [5:0]        in_tx;
    logic [5:0]        in_ty;
    logic signed [7:0] in_delta;
    logic              in_dir;

    logic [DW-1:0]     eff_w;
    logic [DW-1:0]     eff_h;
    logic              accept;
    logic              out_free;
    logic              grid_wr;
    logic              seg_same;
    logic              seg_vert;
    logic [5:0]        sel_x;
    logic [5:0]        sel_y;
    logic              sel_vert;
    logic              sel_in;
    logic [AW-1:0]     sel_idx;
    logic              emit;
    res_t              res_d;

    logic [AW-1:0]        raddr;
    logic                 dem_we;
    logic [AW-1:0]        dem_waddr;
    logic [2*CW-1:0]      dem_wdata;
    logic [2*CW-1:0]      dem_rd;
    logic                 hist_we;
    logic [AW-1:0]        hist_waddr;
    logic [2*CW-1:0]      hist_wdata;
    logic [2*CW-1:0]      hist_rd;

    alu_ctrl_t            alu_ctrl;
    logic [2*CW-1:0]      alu_dem_word;
    logic [CW-1:0]        alu_dem_new;
    logic [2*CW-1:0]      alu_hist_word;
    logic [TOTAL_WIDTH-1:0] alu_ovh;
    logic [TOTAL_WIDTH-1:0] alu_ovv;
    logic [TOTAL_WIDTH+1:0] sum_wide;

    function automatic logic edge_in(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                     input logic vert, input logic [DW-1:0] w,
                                     input logic [DW-1:0] h);
        logic r;
        if (vert)
        begin
            r = (x < w) && ((y + DW'(1)) < h);
        end
        else
        begin
            r = ((x + DW'(1)) < w) && (y < h);
        end
        return r;
    endfunction

    assign in_kind  = s_tuser;
    assign in_fx    = s_tdata[5:0];
    assign in_fy    = s_tdata[11:6];
    assign in_tx    = s_tdata[17:12];
    assign in_ty    = s_tdata[23:18];
    assign in_delta = $signed(s_tdata[31:24]);
    assign in_dir   = s_tdata[32];

    assign eff_w = (DW'(gw_reg) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(gw_reg);
    assign eff_h = (DW'(gh_reg) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(gh_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign grid_wr  = cfg_we && ((cfg_index == REG_GRID_W) || (cfg_index == REG_GRID_H));

    // Pick the edge addressed by the incoming item
    always_comb
    begin
        seg_same = (in_fx == in_tx) && (in_fy == in_ty);
        seg_vert = (in_fy != in_ty);
        if (in_kind == KIND_READ)
        begin
            sel_x    = in_fx;
            sel_y    = in_fy;
            sel_vert = in_dir;
        end
        else if (seg_vert)
        begin
            sel_x    = in_fx;
            sel_y    = (in_fy < in_ty) ? in_fy : in_ty;
            sel_vert = 1'b1;
        end
        else
        begin
            sel_x    = (in_fx < in_tx) ? in_fx : in_tx;
            sel_y    = in_fy;
            sel_vert = 1'b0;
        end
        sel_in  = edge_in(DW'(sel_x), DW'(sel_y), sel_vert, eff_w, eff_h)
                  && !((in_kind == KIND_SEG) && seg_same);
        sel_idx = AW'(AW'(sel_x) * AW'(MAX_DIM)) + AW'(sel_y);
    end

    always_comb
    begin
        alu_ctrl.vert = vert_reg;
        alu_ctrl.in_h = edge_in(DW'(s1_x_reg), DW'(s1_y_reg), 1'b0, eff_w, eff_h);
        alu_ctrl.in_v = edge_in(DW'(s1_x_reg), DW'(s1_y_reg), 1'b1, eff_w, eff_h);
    end

    cmap_alu #(
        .COUNT_WIDTH (CW)
    ) u_alu (
        .dem_word      (dem_rd),
        .hist_word     (hist_rd),
        .delta         (delta_reg),
        .hcap          (hcap_reg),
        .vcap          (vcap_reg),
        .ctrl          (alu_ctrl),
        .dem_word_new  (alu_dem_word),
        .dem_new       (alu_dem_new),
        .hist_word_new (alu_hist_word),
        .ovh           (alu_ovh),
        .ovv           (alu_ovv)
    );

    // Memory ports
    always_comb
    begin
        raddr      = (state_reg == ST_SWEEP) ? cnt_reg : sel_idx;
        dem_we     = (state_reg == ST_CLEAR) || (state_reg == ST_SEG);
        dem_waddr  = (state_reg == ST_CLEAR) ? cnt_reg : addr_reg;
        dem_wdata  = (state_reg == ST_CLEAR) ? '0 : alu_dem_word;
        hist_we    = (state_reg == ST_CLEAR) || (s1_v_reg && (kind_reg == KIND_HIST));
        hist_waddr = (state_reg == ST_CLEAR) ? cnt_reg : s1_addr_reg;
        hist_wdata = (state_reg == ST_CLEAR) ? '0 : alu_hist_word;
    end

    cmap_ram #(
        .WIDTH (2 * CW),
        .DEPTH (DEPTH)
    ) u_dem_ram (
        .clk   (clk),
        .we    (dem_we),
        .waddr (dem_waddr),
        .wdata (dem_wdata),
        .raddr (raddr),
        .rdata (dem_rd)
    );

    cmap_ram #(
        .WIDTH (2 * CW),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (raddr),
        .rdata (hist_rd)
    );

    // Saturating overflow accumulate
    always_comb
    begin
        sum_wide = (TOTAL_WIDTH + 2)'(sum_reg) + (TOTAL_WIDTH + 2)'(ovh_reg)
                   + (TOTAL_WIDTH + 2)'(ovv_reg);
        sum_next = (|sum_wide[TOTAL_WIDTH+1:TOTAL_WIDTH]) ? '1
                                                          : sum_wide[TOTAL_WIDTH-1:0];
    end

    // Result selection and sequencing
    always_comb
    begin
        emit       = 1'b0;
        res_d      = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((in_kind == KIND_HIST) || (in_kind == KIND_OVF))
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (sel_in)
                    begin
                        state_next = (in_kind == KIND_SEG) ? ST_SEG : ST_READ;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            ST_SEG:
            begin
                emit           = 1'b1;
                res_d.demand   = FIELD_WIDTH'(alu_dem_new);
                res_d.history  = vert_reg ? FIELD_WIDTH'(hist_rd[2*CW-1:CW])
                                          : FIELD_WIDTH'(hist_rd[CW-1:0]);
                res_d.capacity = vert_reg ? vcap_reg : hcap_reg;
                res_d.valid    = 1'b1;
            end
            ST_READ:
            begin
                emit           = 1'b1;
                res_d.demand   = vert_reg ? FIELD_WIDTH'(dem_rd[2*CW-1:CW])
                                          : FIELD_WIDTH'(dem_rd[CW-1:0]);
                res_d.history  = vert_reg ? FIELD_WIDTH'(hist_rd[2*CW-1:CW])
                                          : FIELD_WIDTH'(hist_rd[CW-1:0]);
                res_d.capacity = vert_reg ? vcap_reg : hcap_reg;
                res_d.valid    = 1'b1;
            end
            ST_SWEEP:
            begin
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg)
                begin
                    emit        = 1'b1;
                    res_d.total = (kind_reg == KIND_OVF) ? sum_reg : '0;
                end
            end
            ST_HOLD:
            begin
                emit  = 1'b1;
                res_d = res_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (emit)
        begin
            state_next = out_free ? ST_IDLE : ST_HOLD;
        end
        // Grid size writes restart the clearing pass
        if (grid_wr)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Control state, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            gw_reg       <= 7'd64;
            gh_reg       <= 7'd64;
            hcap_reg     <= '0;
            vcap_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= (state_reg == ST_SWEEP);
            s2_v_reg  <= s1_v_reg;

            if (grid_wr)
            begin
                cnt_reg <= '0;
            end
            else if ((state_reg == ST_IDLE) && accept)
            begin
                cnt_reg <= '0;
                x_reg   <= '0;
                y_reg   <= '0;
            end
            else if ((state_reg == ST_CLEAR) || (state_reg == ST_SWEEP))
            begin
                cnt_reg <= cnt_reg + AW'(1);
                if (y_reg == LAST_XY)
                begin
                    y_reg <= '0;
                    x_reg <= x_reg + XW'(1);
                end
                else
                begin
                    y_reg <= y_reg + XW'(1);
                end
            end

            if (emit && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GRID_W:
                    begin
                        gw_reg <= cfg_data[6:0];
                    end
                    REG_GRID_H:
                    begin
                        gh_reg <= cfg_data[6:0];
                    end
                    REG_HCAP:
                    begin
                        hcap_reg <= cfg_data;
                    end
                    REG_VCAP:
                    begin
                        vcap_reg <= cfg_data;
                    end
                    default:
                    begin
                        hcap_reg <= hcap_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= in_kind;
            vert_reg  <= sel_vert;
            delta_reg <= in_delta;
            addr_reg  <= sel_idx;
        end

        s1_addr_reg <= cnt_reg;
        s1_x_reg    <= x_reg;
        s1_y_reg    <= y_reg;
        ovh_reg     <= alu_ovh;
        ovv_reg     <= alu_ovv;

        if (accept)
        begin
            sum_reg <= '0;
        end
        else if (s2_v_reg)
        begin
            sum_reg <= sum_next;
        end

        if (emit && !out_free)
        begin
            res_reg <= res_d;
        end

        if (emit && out_free)
        begin
            m_res_reg <= res_d;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_res_reg.total, m_res_reg.capacity, m_res_reg.history,
                       m_res_reg.demand};
    assign m_tuser  = m_res_reg.valid;

endmodule

// ----- verif/routing_grid_congestion_map_test.sv -----
`timescale 1ns / 100ps
// Self-checking stream testbench for the routing grid congestion map.
module routing_grid_congestion_map_test;
    import cmap_pkg::*;

    localparam int GRID_MAX = 64;
    localparam int CELL_COUNT = GRID_MAX * GRID_MAX;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    typedef struct {
        logic [1:0]        kind;
        logic [5:0]        fx;
        logic [5:0]        fy;
        logic [5:0]        tx;
        logic [5:0]        ty;
        logic signed [7:0] delta;
        logic              dir;
    } grid_op_t;

    // One directed row: operation, then the result where it is typed in
    typedef struct {
        logic [1:0]        kind;
        logic [5:0]        fx;
        logic [5:0]        fy;
        logic [5:0]        tx;
        logic [5:0]        ty;
        logic signed [7:0] delta;
        logic              dir;
        bit                typed;
        logic [15:0]       dem;
        logic [15:0]       hist;
        logic [15:0]       cap;
        logic [31:0]       tot;
        logic              vld;
    } dir_row_t;

    typedef struct {
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] hc;
        logic [15:0] vc;
        int          count;
        bit          sat;
    } phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Mirror of the block: four counter stores and the registers
    logic [15:0] h_demand [CELL_COUNT];
    logic [15:0] v_demand [CELL_COUNT];
    logic [15:0] h_history [CELL_COUNT];
    logic [15:0] v_history [CELL_COUNT];
    logic [6:0]  grid_w_reg;
    logic [6:0]  grid_h_reg;
    logic [15:0] h_cap;
    logic [15:0] v_cap;

    res_t due_results [$];
    int   err_count = 0;
    int   fed = 0;
    bit   feed_calm = 1'b0;

    dir_row_t directed_rows [22] = '{
        '{KIND_READ, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 1},
        '{KIND_READ, 63, 62, 0, 0, 0, 1, 1'b1, 0, 0, 0, 0, 1},
        '{KIND_READ, 63, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0},
        '{KIND_READ, 0, 63, 0, 0, 0, 1, 1'b1, 0, 0, 0, 0, 0},
        '{KIND_SEG, 5, 5, 5, 5, 10, 0, 1'b1, 0, 0, 0, 0, 0},
        '{KIND_SEG, 0, 0, 1, 0, 127, 0, 1'b1, 127, 0, 0, 0, 1},
        '{KIND_SEG, 1, 0, 0, 0, -128, 0, 1'b1, 0, 0, 0, 0, 1},
        '{KIND_SEG, 0, 0, 0, 1, 127, 1, 1'b1, 127, 0, 0, 0, 1},
        '{KIND_SEG, 3, 4, 5, 2, 5, 0, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_SEG, 10, 7, 20, 7, 3, 0, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_SEG, 63, 63, 62, 63, 1, 1, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_SEG, 63, 63, 63, 62, 2, 0, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_SEG, 63, 0, 63, 63, -1, 0, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_SEG, 63, 5, 0, 5, 100, 0, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_HIST, 63, 63, 63, 63, -1, 1, 1'b1, 0, 0, 0, 0, 0},
        '{KIND_OVF, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_READ, 0, 0, 42, 21, -86, 0, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_READ, 0, 0, 0, 0, 0, 1, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_HIST, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_OVF, 21, 42, 21, 42, 85, 1, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_READ, 3, 2, 0, 0, 0, 1, 1'b0, 0, 0, 0, 0, 0},
        '{KIND_SEG, 63, 63, 63, 63, -128, 1, 1'b1, 0, 0, 0, 0, 0}
    };

    phase_t phases [8] = '{
        '{16'd64, 16'd64, 16'd2, 16'd1, 200, 1'b0},
        '{16'd8, 16'd8, 16'd40, 16'd0, 250, 1'b0},
        '{16'd2, 16'd1, 16'd65534, 16'd65535, 600, 1'b1},
        '{16'd1, 16'd1, 16'd0, 16'd0, 40, 1'b0},
        '{16'd0, 16'd5, 16'd0, 16'd0, 30, 1'b0},
        '{16'd127, 16'd65, 16'd65535, 16'd3, 150, 1'b0},
        '{16'd3, 16'd64, 16'd5, 16'd65535, 150, 1'b0},
        '{16'd64, 16'd2, 16'd1, 16'd0, 150, 1'b0}
    };

    always #10 clk = ~clk;

    routing_grid_congestion_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int eff_dim(logic [6:0] v);
        return (v > GRID_MAX) ? GRID_MAX : int'(v);
    endfunction

    function automatic bit link_in_grid(int x, int y, bit vert);
        int w;
        int h;
        w = eff_dim(grid_w_reg);
        h = eff_dim(grid_h_reg);
        if (vert)
            return h >= 2 && x < w && y < h - 1;
        return w >= 2 && x < w - 1 && y < h;
    endfunction

    function automatic void clear_maps();
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            h_demand[i] = '0;
            v_demand[i] = '0;
            h_history[i] = '0;
            v_history[i] = '0;
        end
    endfunction

    function automatic res_t peek_link(int x, int y, bit vert);
        res_t r;
        int idx;
        r = '0;
        idx = x * GRID_MAX + y;
        r.demand = vert ? v_demand[idx] : h_demand[idx];
        r.history = vert ? v_history[idx] : h_history[idx];
        r.capacity = vert ? v_cap : h_cap;
        r.valid = 1'b1;
        return r;
    endfunction

    // Advance the mirror by one operation and return the result it causes
    function automatic res_t apply_op(grid_op_t op);
        res_t r;
        int x;
        int y;
        int idx;
        int cur;
        int step;
        bit vert;
        longint total;
        r = '0;
        case (op.kind)
            KIND_SEG:
            begin
                if (!(op.fx == op.tx && op.fy == op.ty))
                begin
                    if (op.fy == op.ty)
                    begin
                        vert = 1'b0;
                        x = int'((op.fx < op.tx) ? op.fx : op.tx);
                        y = int'(op.fy);
                    end
                    else
                    begin
                        vert = 1'b1;
                        x = int'(op.fx);
                        y = int'((op.fy < op.ty) ? op.fy : op.ty);
                    end
                    if (link_in_grid(x, y, vert))
                    begin
                        idx = x * GRID_MAX + y;
                        cur = int'(vert ? v_demand[idx] : h_demand[idx]);
                        step = int'(op.delta);
                        cur = cur + step;
                        if (cur < 0)
                            cur = 0;
                        if (cur > COUNT_TOP)
                            cur = COUNT_TOP;
                        if (vert)
                            v_demand[idx] = cur[15:0];
                        else
                            h_demand[idx] = cur[15:0];
                        r = peek_link(x, y, vert);
                    end
                end
            end
            KIND_HIST:
            begin
                for (int i = 0; i < CELL_COUNT; i++)
                begin
                    x = i / GRID_MAX;
                    y = i % GRID_MAX;
                    if (link_in_grid(x, y, 1'b0) && h_demand[i] > h_cap
                        && h_history[i] != COUNT_TOP)
                        h_history[i] = h_history[i] + 16'd1;
                    if (link_in_grid(x, y, 1'b1) && v_demand[i] > v_cap
                        && v_history[i] != COUNT_TOP)
                        v_history[i] = v_history[i] + 16'd1;
                end
            end
            KIND_OVF:
            begin
                total = 0;
                for (int i = 0; i < CELL_COUNT; i++)
                begin
                    x = i / GRID_MAX;
                    y = i % GRID_MAX;
                    if (link_in_grid(x, y, 1'b0) && h_demand[i] > h_cap)
                        total += longint'(h_demand[i]) - longint'(h_cap);
                    if (link_in_grid(x, y, 1'b1) && v_demand[i] > v_cap)
                        total += longint'(v_demand[i]) - longint'(v_cap);
                end
                if (total > 64'hFFFF_FFFF)
                    total = 64'hFFFF_FFFF;
                r.total = total[31:0];
            end
            KIND_READ:
            begin
                if (link_in_grid(int'(op.fx), int'(op.fy), op.dir))
                    r = peek_link(int'(op.fx), int'(op.fy), op.dir);
            end
        endcase
        return r;
    endfunction

    // Mostly short segments inside the grid in use, with some noise anywhere
    function automatic grid_op_t rand_op();
        grid_op_t op;
        int pick;
        int shape;
        int w;
        int h;
        w = eff_dim(grid_w_reg);
        h = eff_dim(grid_h_reg);
        if (w == 0)
            w = 1;
        if (h == 0)
            h = 1;
        pick = $urandom_range(0, 99);
        op.kind = (pick < 75) ? KIND_SEG : (pick < 94) ? KIND_READ :
                  (pick < 97) ? KIND_HIST : KIND_OVF;
        op.fx = 6'($urandom_range(0, w - 1));
        op.fy = 6'($urandom_range(0, h - 1));
        op.tx = op.fx;
        op.ty = op.fy;
        op.dir = 1'($urandom_range(0, 1));
        op.delta = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, 127))
                                              : 8'($urandom_range(0, 255));
        shape = $urandom_range(0, 19);
        if (shape < 4)
            op.tx = op.fx + 6'd1;
        else if (shape < 8)
            op.tx = op.fx - 6'd1;
        else if (shape < 12)
            op.ty = op.fy + 6'd1;
        else if (shape < 16)
            op.ty = op.fy - 6'd1;
        else if (shape == 16)
        begin
            op.tx = op.fx + 6'd1;
            op.ty = op.fy - 6'd1;
        end
        else if (shape == 18)
            op.tx = 6'($urandom_range(0, 63));
        else if (shape == 19)
        begin
            op.fx = 6'($urandom_range(0, 63));
            op.fy = 6'($urandom_range(0, 63));
            op.tx = 6'($urandom_range(0, 63));
            op.ty = 6'($urandom_range(0, 63));
        end
        return op;
    endfunction

    // Pile demand onto the one horizontal link of a 2x1 grid
    function automatic grid_op_t pile_op();
        grid_op_t op;
        op.kind = KIND_SEG;
        op.fx = 6'($urandom_range(0, 1));
        op.tx = 6'd1 - op.fx;
        op.fy = '0;
        op.ty = '0;
        op.delta = 8'($urandom_range(120, 127));
        op.dir = 1'($urandom_range(0, 1));
        return op;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic send_op(input grid_op_t op, input bit typed, input res_t want);
        int gap;
        res_t pred;
        if (fed % 40 == 0)
            feed_calm = ($urandom_range(0, 3) == 0);
        gap = feed_calm ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, op.dir, op.delta, op.ty, op.tx, op.fy, op.fx};
        s_tuser <= op.kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = apply_op(op);
        due_results.insert(due_results.size(), typed ? want : pred);
        fed++;
    endtask

    // Hold the input idle until every pending result is back
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GRID_W: grid_w_reg = value[6:0];
            REG_GRID_H: grid_h_reg = value[6:0];
            REG_HCAP:   h_cap = value;
            REG_VCAP:   v_cap = value;
        endcase
        // a new grid size wipes the stores; let the clearing pass run out
        if (idx == REG_GRID_W || idx == REG_GRID_H)
        begin
            clear_maps();
            repeat (CELL_COUNT + 8) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        grid_op_t op;
        res_t want;
        grid_w_reg = 7'd64;
        grid_h_reg = 7'd64;
        h_cap = '0;
        v_cap = '0;
        clear_maps();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            op.kind = directed_rows[i].kind;
            op.fx = directed_rows[i].fx;
            op.fy = directed_rows[i].fy;
            op.tx = directed_rows[i].tx;
            op.ty = directed_rows[i].ty;
            op.delta = directed_rows[i].delta;
            op.dir = directed_rows[i].dir;
            want = '0;
            want.demand = directed_rows[i].dem;
            want.history = directed_rows[i].hist;
            want.capacity = directed_rows[i].cap;
            want.total = directed_rows[i].tot;
            want.valid = directed_rows[i].vld;
            send_op(op, directed_rows[i].typed, want);
        end
        settle();

        foreach (phases[p])
        begin
            write_reg(REG_HCAP, phases[p].hc);
            write_reg(REG_VCAP, phases[p].vc);
            write_reg(REG_GRID_W, phases[p].w);
            write_reg(REG_GRID_H, phases[p].h);
            for (int n = 0; n < phases[p].count; n++)
            begin
                if (phases[p].sat && n < phases[p].count - 50)
                    op = pile_op();
                else
                    op = rand_op();
                send_op(op, 1'b0, '0);
            end
            settle();
        end

        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("routing_grid_congestion_map_test: clean");
        else
            $display("routing_grid_congestion_map_test: errors");
        $finish;
    end

    initial
    begin : result_side
        int gap;
        int seen;
        bit calm;
        res_t exp;
        seen = 0;
        calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (seen % 48 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 12);
            // long hold-off so the block backs up and stalls its input
            if (seen == 120)
                gap = 400;
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            seen++;
            if (due_results.size() == 0)
                flag_error("result transaction with nothing pending");
            else
            begin
                exp = due_results.pop_front();
                if (m_tdata[15:0] !== exp.demand)
                    flag_error($sformatf("edge_demand expected %0d got %0d",
                                         exp.demand, m_tdata[15:0]));
                if (m_tdata[31:16] !== exp.history)
                    flag_error($sformatf("edge_history expected %0d got %0d",
                                         exp.history, m_tdata[31:16]));
                if (m_tdata[47:32] !== exp.capacity)
                    flag_error($sformatf("edge_capacity expected %0d got %0d",
                                         exp.capacity, m_tdata[47:32]));
                if (m_tdata[79:48] !== exp.total)
                    flag_error($sformatf("ovf_total expected %0d got %0d",
                                         exp.total, m_tdata[79:48]));
                if (m_tuser[0] !== exp.valid)
                    flag_error($sformatf("edge_valid expected %0d got %0d",
                                         exp.valid, m_tuser[0]));
            end
        end
    end

    initial
    begin : watchdog
        #100_000_000;
        $display("routing_grid_congestion_map_test: errors");
        $finish;
    end

endmodule
